@@ sv/lzwe_pkg.sv @@
package lzwe_pkg;

   localparam int ROOT_CODES     = 256;
   localparam int INIT_WIDTH     = 8;
   localparam int MIN_BITS       = 8;
   localparam int RESET_MAX_BITS = 12;

   localparam logic ACT_DATA  = 1'b0;
   localparam logic ACT_FLUSH = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PROBE_IDX,
      ST_PROBE_KEY,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic        valid;
      logic [15:0] code;
      logic [4:0]  code_width;
      logic        last;
   } emit_type;

endpackage

@@ sv/lzwe_ram.sv @@
module lzwe_ram #(
   parameter int AW = 10,
   parameter int DW = 16
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [DW-1:0] wdata,
   input  logic [AW-1:0] raddr,
   output logic [DW-1:0] rdata
);

   logic [DW-1:0] mem [2**AW];
   logic [DW-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ sv/lzwe_ctrl.sv @@
module lzwe_ctrl #(
   parameter int MAX_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_action,
   input  logic [7:0]        req_data_byte,
   input  logic [4:0]        max_code_bits,
   input  logic              emit_ready,
   output lzwe_pkg::emit_type emit
);

   localparam int SB = MAX_BITS + 1;   // slot address bits
   localparam int CW = MAX_BITS + 1;   // entry count bits
   localparam int KW = MAX_BITS + 8;   // key: prefix and byte

   lzwe_pkg::state_type state_ff, state_in;
   lzwe_pkg::emit_type  out_ff, out_in;

   logic [SB-1:0]       clr_ff, clr_in;
   logic [MAX_BITS-1:0] prefix_ff, prefix_in;
   logic                pvalid_ff, pvalid_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       limit_ff, limit_in;
   logic [4:0]          width_ff, width_in;
   logic [7:0]          byte_ff, byte_in;
   logic [SB-1:0]       slot_ff, slot_in;
   logic [MAX_BITS-1:0] idx_ff, idx_in;

   logic                slot_we;
   logic [SB-1:0]       slot_waddr, slot_raddr;
   logic [MAX_BITS-1:0] slot_wdata, slot_rdata;
   logic                dict_we;
   logic [MAX_BITS-1:0] dict_raddr;
   logic [KW-1:0]       dict_rdata;

   logic [KW-1:0]       key;
   logic [4:0]          m_eff;
   logic [CW-1:0]       capacity;
   logic                live, can_add, grow;
   logic [4:0]          width_new;
   logic [SB-1:0]       hash_new;

   lzwe_ram #(.AW(SB), .DW(MAX_BITS)) u_slot_ram (
      .clock (clock),
      .we    (slot_we),
      .waddr (slot_waddr),
      .wdata (slot_wdata),
      .raddr (slot_raddr),
      .rdata (slot_rdata)
   );

   lzwe_ram #(.AW(MAX_BITS), .DW(KW)) u_dict_ram (
      .clock (clock),
      .we    (dict_we),
      .waddr (count_ff[MAX_BITS-1:0]),
      .wdata (key),
      .raddr (dict_raddr),
      .rdata (dict_rdata)
   );

   always_comb begin
      key = {prefix_ff, byte_ff};
      if (max_code_bits < 5'(lzwe_pkg::MIN_BITS)) begin
         m_eff = 5'(lzwe_pkg::MIN_BITS);
      end else if (max_code_bits > 5'(MAX_BITS)) begin
         m_eff = 5'(MAX_BITS);
      end else begin
         m_eff = max_code_bits;
      end
      capacity  = CW'(1) << m_eff;
      live      = (slot_rdata >= MAX_BITS'(lzwe_pkg::ROOT_CODES)) &&
                  ({1'b0, slot_rdata} < count_ff);
      can_add   = count_ff < capacity;
      grow      = count_ff > limit_ff;
      width_new = (can_add && grow) ? width_ff + 5'd1 : width_ff;
      hash_new  = SB'(prefix_ff) ^ {req_data_byte, (SB-8)'(0)};
   end

   always_comb begin
      state_in   = state_ff;
      out_in     = out_ff;
      clr_in     = clr_ff;
      prefix_in  = prefix_ff;
      pvalid_in  = pvalid_ff;
      count_in   = count_ff;
      limit_in   = limit_ff;
      width_in   = width_ff;
      byte_in    = byte_ff;
      slot_in    = slot_ff;
      idx_in     = idx_ff;
      req_stall  = 1'b1;
      slot_we    = 1'b0;
      slot_waddr = slot_ff;
      slot_wdata = count_ff[MAX_BITS-1:0];
      slot_raddr = hash_new;
      dict_we    = 1'b0;
      dict_raddr = slot_rdata;

      case (state_ff)
         lzwe_pkg::ST_CLEAR: begin
            slot_we    = 1'b1;
            slot_waddr = clr_ff;
            slot_wdata = '0;
            clr_in     = clr_ff + SB'(1);
            if (&clr_ff) begin
               state_in = lzwe_pkg::ST_IDLE;
            end
         end
         lzwe_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_action == lzwe_pkg::ACT_FLUSH) begin
                  if (pvalid_ff) begin
                     out_in   = '{1'b1, 16'(prefix_ff), width_ff, 1'b1};
                     state_in = lzwe_pkg::ST_EMIT;
                  end
                  prefix_in = '0;
                  pvalid_in = 1'b0;
                  count_in  = CW'(lzwe_pkg::ROOT_CODES);
                  limit_in  = CW'(lzwe_pkg::ROOT_CODES);
                  width_in  = 5'(lzwe_pkg::INIT_WIDTH);
               end else if (!pvalid_ff) begin
                  prefix_in = MAX_BITS'(req_data_byte);
                  pvalid_in = 1'b1;
               end else begin
                  byte_in  = req_data_byte;
                  slot_in  = hash_new;
                  state_in = lzwe_pkg::ST_PROBE_IDX;
               end
            end
         end
         lzwe_pkg::ST_PROBE_IDX: begin
            if (live) begin
               idx_in   = slot_rdata;
               state_in = lzwe_pkg::ST_PROBE_KEY;
            end else begin
               // miss: slot is free, add the new entry there if the dictionary has room
               if (can_add) begin
                  slot_we  = 1'b1;
                  dict_we  = 1'b1;
                  count_in = count_ff + CW'(1);
                  if (grow) begin
                     width_in = width_ff + 5'd1;
                     limit_in = limit_ff << 1;
                  end
               end
               out_in    = '{1'b1, 16'(prefix_ff), width_new, 1'b0};
               prefix_in = MAX_BITS'(byte_ff);
               state_in  = lzwe_pkg::ST_EMIT;
            end
         end
         lzwe_pkg::ST_PROBE_KEY: begin
            if (dict_rdata == key) begin
               prefix_in = idx_ff;
               state_in  = lzwe_pkg::ST_IDLE;
            end else begin
               slot_in    = slot_ff + SB'(1);
               slot_raddr = slot_ff + SB'(1);
               state_in   = lzwe_pkg::ST_PROBE_IDX;
            end
         end
         lzwe_pkg::ST_EMIT: begin
            if (emit_ready) begin
               state_in = lzwe_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lzwe_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= lzwe_pkg::ST_CLEAR;
         clr_ff    <= '0;
         prefix_ff <= '0;
         pvalid_ff <= 1'b0;
         count_ff  <= CW'(lzwe_pkg::ROOT_CODES);
         limit_ff  <= CW'(lzwe_pkg::ROOT_CODES);
         width_ff  <= 5'(lzwe_pkg::INIT_WIDTH);
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         prefix_ff <= prefix_in;
         pvalid_ff <= pvalid_in;
         count_ff  <= count_in;
         limit_ff  <= limit_in;
         width_ff  <= width_in;
      end
      out_ff  <= out_in;
      byte_ff <= byte_in;
      slot_ff <= slot_in;
      idx_ff  <= idx_in;
   end

   always_comb begin
      emit       = out_ff;
      emit.valid = (state_ff == lzwe_pkg::ST_EMIT);
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (CW'(1) << MAX_BITS))
      else $error("entry count past dictionary size");

   a_width_range: assert property (@(posedge clock) disable iff (reset)
      width_ff >= 5'(lzwe_pkg::INIT_WIDTH) && width_ff <= 5'(MAX_BITS))
      else $error("code width out of range");

   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_action == lzwe_pkg::ACT_FLUSH)
      |=> (!pvalid_ff && count_ff == CW'(lzwe_pkg::ROOT_CODES)))
      else $error("flush left stream state behind");

   a_no_emit_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lzwe_pkg::ST_CLEAR) |-> (!emit.valid && req_stall))
      else $error("activity during slot clearing");

   a_insert_on_miss: assert property (@(posedge clock) disable iff (reset)
      dict_we |-> (state_ff == lzwe_pkg::ST_PROBE_IDX && !live))
      else $error("dictionary write outside a miss");

endmodule

@@ sv/lzw_variable_width_encoder_top.sv @@
// LZW encoder with growing code width. Each data word (action 0) extends the
// current prefix; when the (prefix, byte) pair is not in the dictionary the
// prefix code goes out with its width and a new entry is added, until
// 2^max_code_bits entries exist (max_code_bits clamped to 8..MAX_BITS). A
// flush word (action 1) sends the pending prefix with last set and starts a
// fresh stream. Lookup is a hashed, linearly probed slot table in one RAM
// plus the entry store in a second RAM, both with registered reads. A byte
// that needs a lookup is accepted, then the slot at its hash is read. A slot
// in use adds a read of its stored key; on a key mismatch the next slot is
// probed. A miss, or a flush with a pending code, then hands the code to the
// output register. The hand-off waits while the output register still holds
// a code stalled by rsp_stall. After reset the slot RAM is zeroed, one entry
// a cycle, before the first word is taken; csr writes are accepted at any
// time. The output register lets the next word in while a code waits on
// rsp_stall.
module lzw_variable_width_encoder_top #(
   parameter int MAX_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_code,
   output logic [4:0]  rsp_code_width,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [4:0]  csr_max_code_bits
);

   logic [4:0] max_bits_ff, max_bits_in;   // raw register, clamped in ctrl

   lzwe_pkg::emit_type emit;
   logic               emit_ready;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] code_ff, code_in;
   logic [4:0]  cwidth_ff, cwidth_in;
   logic        last_ff, last_in;

   assign csr_ready = 1'b1;

   always_comb begin
      max_bits_in = max_bits_ff;
      if (csr_valid && csr_ready) begin
         max_bits_in = csr_max_code_bits;
      end
   end

   lzwe_ctrl #(.MAX_BITS(MAX_BITS)) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_action    (req_action),
      .req_data_byte (req_data_byte),
      .max_code_bits (max_bits_ff),
      .emit_ready    (emit_ready),
      .emit          (emit)
   );

   // output word register: loads when empty or being drained
   assign emit_ready = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      code_in      = code_ff;
      cwidth_in    = cwidth_ff;
      last_in      = last_ff;
      if (emit_ready) begin
         rsp_valid_in = emit.valid;
         if (emit.valid) begin
            code_in   = emit.code;
            cwidth_in = emit.code_width;
            last_in   = emit.last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_bits_ff  <= 5'(lzwe_pkg::RESET_MAX_BITS);
         rsp_valid_ff <= 1'b0;
      end else begin
         max_bits_ff  <= max_bits_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      code_ff   <= code_in;
      cwidth_ff <= cwidth_in;
      last_ff   <= last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_code       = code_ff;
   assign rsp_code_width = cwidth_ff;
   assign rsp_last       = last_ff;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

   // ---------------------------------------------------------------------------
   // DUT signals
   // ---------------------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_action = lzwe_pkg::ACT_DATA;
   logic [7:0]  req_data_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_code;
   logic [4:0]  rsp_code_width;
   logic        rsp_last;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [4:0]  csr_max_code_bits = 5'd0;

   localparam int DICT_ENTRIES = 1 << 16;
   // slot RAM clear after reset covers 2^17 slots; leave plenty of room
   localparam int WATCHDOG_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 200;

   always #2 clock = ~clock;

   lzw_variable_width_encoder_top #(.MAX_BITS(16)) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_action(req_action),
      .req_data_byte(req_data_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_code(rsp_code),
      .rsp_code_width(rsp_code_width),
      .rsp_last(rsp_last),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_max_code_bits(csr_max_code_bits)
   );

   // ---------------------------------------------------------------------------
   // Encoder model: prefix, entry count, width state and the dictionary
   // ---------------------------------------------------------------------------
   typedef struct packed {
      logic [15:0] code;
      logic [4:0]  code_width;
      logic        last;
   } code_word_type;

   logic [4:0]  mdl_max_bits;
   logic [15:0] mdl_prefix;
   bit          mdl_prefix_valid;
   int unsigned mdl_entries;
   int unsigned mdl_width_limit;
   logic [4:0]  mdl_width;
   int unsigned mdl_dict[int unsigned];   // key {prefix, byte} -> entry number

   code_word_type pending_codes[$];
   int          errors = 0;
   int          codes_seen = 0;
   int          flush_codes = 0;
   int          words_sent = 0;
   int          max_width_seen = 0;

   function automatic void clear_stream();
      mdl_prefix       = 16'd0;
      mdl_prefix_valid = 1'b0;
      mdl_entries      = lzwe_pkg::ROOT_CODES;
      mdl_width_limit  = lzwe_pkg::ROOT_CODES;
      mdl_width        = 5'(lzwe_pkg::INIT_WIDTH);
      mdl_dict.delete();
   endfunction

   // Returns 1 when the word produces a code, placed in cw.
   function automatic bit encode_word(input logic act, input logic [7:0] b,
                                      output code_word_type cw);
      int unsigned key;
      int unsigned m;
      int unsigned cap;
      cw = '0;
      if (act == lzwe_pkg::ACT_FLUSH) begin
         encode_word = mdl_prefix_valid;
         cw.code = mdl_prefix;
         cw.code_width = mdl_width;
         cw.last = 1'b1;
         clear_stream();
         return encode_word;
      end
      if (!mdl_prefix_valid) begin
         mdl_prefix = {8'd0, b};
         mdl_prefix_valid = 1'b1;
         return 1'b0;
      end
      key = 32'({mdl_prefix, b});
      if (mdl_dict.exists(key) && mdl_dict[key] < mdl_entries) begin
         mdl_prefix = mdl_dict[key][15:0];
         return 1'b0;
      end
      m = 32'(mdl_max_bits);
      if (m < lzwe_pkg::MIN_BITS) m = lzwe_pkg::MIN_BITS;
      if (m > 16) m = 16;
      cap = 1 << m;
      if (mdl_entries < cap && mdl_entries < DICT_ENTRIES) begin
         mdl_dict[key] = mdl_entries;
         if (mdl_entries > mdl_width_limit) begin
            mdl_width = mdl_width + 5'd1;
            mdl_width_limit = mdl_width_limit << 1;
         end
         mdl_entries++;
      end
      cw.code = mdl_prefix;
      cw.code_width = mdl_width;
      cw.last = 1'b0;
      mdl_prefix = {8'd0, b};
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------------------
   // Output check: every accepted code against the oldest expected one
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         code_word_type exp_cw;
         codes_seen++;
         if (pending_codes.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("ERROR: unexpected code %0d width %0d last %0d",
                        rsp_code, rsp_code_width, rsp_last);
         end else begin
            exp_cw = pending_codes.pop_front();
            if (rsp_last) flush_codes++;
            if (int'(rsp_code_width) > max_width_seen)
               max_width_seen = int'(rsp_code_width);
            if (rsp_code !== exp_cw.code || rsp_code_width !== exp_cw.code_width ||
                rsp_last !== exp_cw.last) begin
               errors++;
               if (errors <= 10)
                  $display("ERROR: code exp %0d/%0d/%0d got %0d/%0d/%0d",
                           exp_cw.code, exp_cw.code_width, exp_cw.last,
                           rsp_code, rsp_code_width, rsp_last);
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Receiver stall pattern: modes of no stall, light random, long stretches
   // ---------------------------------------------------------------------------
   int stall_mode = 0;
   int stall_left = 0;
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 2);
         stall_left <= $urandom_range(10, 80);
         rsp_stall <= 1'b0;
      end else begin
         stall_left <= stall_left - 1;
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            default: rsp_stall <= ($urandom_range(0, 4) != 0);
         endcase
      end
   end

   // ---------------------------------------------------------------------------
   // Watchdog: cycles without any handshake
   // ---------------------------------------------------------------------------
   int idle_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Timeout after %0d idle cycles", idle_cycles);
         $display("Verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------
   int burst_left = 0;

   // Drive one word, hold it until taken, then predict. Gaps come between bursts.
   task automatic send_word(input logic act, input logic [7:0] b,
                            input bit typed, input code_word_type typed_cw);
      code_word_type cw;
      bit has_code;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if ($urandom_range(0, 2) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
      burst_left--;
      req_valid     <= 1'b1;
      req_action    <= act;
      req_data_byte <= b;
      do @(posedge clock); while (req_stall);
      words_sent++;
      has_code = encode_word(act, b, cw);
      if (typed) begin
         if (!has_code || cw !== typed_cw) begin
            errors++;
            if (errors <= 10)
               $display("ERROR: directed row model disagrees with table");
         end
         pending_codes.push_back(typed_cw);
      end else if (has_code)
         pending_codes.push_back(cw);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_codes.size() != 0) @(posedge clock);
      // a word with no code may still be probing
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_max_bits(input logic [4:0] v);
      csr_valid         <= 1'b1;
      csr_max_code_bits <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      mdl_max_bits = v;
   endtask

   // ---------------------------------------------------------------------------
   // Directed table
   // ---------------------------------------------------------------------------
   typedef struct {
      logic          act;
      logic [7:0]    b;
      bit            typed;
      code_word_type cw;
   } dir_row_type;

   dir_row_type dir_rows[] = '{
      '{lzwe_pkg::ACT_FLUSH, 8'hA5, 1'b0, '0},                      // flush, nothing pending
      '{lzwe_pkg::ACT_DATA,  8'h00, 1'b0, '0},                      // first byte, no code
      '{lzwe_pkg::ACT_DATA,  8'hFF, 1'b1, '{16'd0, 5'd8, 1'b0}},    // first miss
      '{lzwe_pkg::ACT_DATA,  8'hFF, 1'b0, '0},                      // width grows
      '{lzwe_pkg::ACT_DATA,  8'hFF, 1'b0, '0},                      // hit on (FF,FF)
      '{lzwe_pkg::ACT_DATA,  8'h41, 1'b0, '0},
      '{lzwe_pkg::ACT_FLUSH, 8'h00, 1'b0, '0},                      // pending code, last set
      '{lzwe_pkg::ACT_FLUSH, 8'hFF, 1'b0, '0},                      // empty flush again
      '{lzwe_pkg::ACT_DATA,  8'h7F, 1'b0, '0},
      '{lzwe_pkg::ACT_FLUSH, 8'h3C, 1'b1, '{16'd127, 5'd8, 1'b1}},  // single byte stream
      '{lzwe_pkg::ACT_DATA,  8'h41, 1'b0, '0},
      '{lzwe_pkg::ACT_DATA,  8'h42, 1'b0, '0},
      '{lzwe_pkg::ACT_DATA,  8'h41, 1'b0, '0},
      '{lzwe_pkg::ACT_DATA,  8'h42, 1'b0, '0},
      '{lzwe_pkg::ACT_DATA,  8'h41, 1'b0, '0},
      '{lzwe_pkg::ACT_DATA,  8'h42, 1'b0, '0},
      '{lzwe_pkg::ACT_DATA,  8'h41, 1'b0, '0},
      '{lzwe_pkg::ACT_DATA,  8'h42, 1'b0, '0},
      '{lzwe_pkg::ACT_DATA,  8'h41, 1'b0, '0},
      '{lzwe_pkg::ACT_DATA,  8'h80, 1'b0, '0},
      '{lzwe_pkg::ACT_DATA,  8'h01, 1'b0, '0},
      '{lzwe_pkg::ACT_FLUSH, 8'h55, 1'b0, '0}
   };

   // Register settings per phase; 31 and 0..7 exercise the clamp
   int phase_bits[]  = '{9, 8, 0, 16, 31, 10, 9, 13, 3, 11, 14, 15, 12, 9};
   int phase_items[] = '{400, 60, 60, 150, 100, 150, 80, 100, 60, 100, 100, 100, 80, 60};

   // ---------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------
   initial begin
      code_word_type none;
      int alphabet;
      int stream_left;
      none = '0;
      mdl_max_bits = 5'(lzwe_pkg::RESET_MAX_BITS);
      clear_stream();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i])
         send_word(dir_rows[i].act, dir_rows[i].b, dir_rows[i].typed, dir_rows[i].cw);
      wait_idle();

      foreach (phase_bits[p]) begin
         write_max_bits(phase_bits[p][4:0]);
         stream_left = (p == 0) ? 1000 : $urandom_range(1, 60);
         alphabet = (p == 0) ? 255 : ($urandom_range(0, 1) ? 255 : $urandom_range(1, 7));
         for (int k = 0; k < phase_items[p]; k++) begin
            if (stream_left == 0 || $urandom_range(0, 199) == 0) begin
               send_word(lzwe_pkg::ACT_FLUSH, 8'($urandom_range(0, 255)), 1'b0, none);
               stream_left = $urandom_range(1, 60);
               alphabet = $urandom_range(0, 1) ? 255 : $urandom_range(1, 7);
            end else begin
               send_word(lzwe_pkg::ACT_DATA, 8'($urandom_range(0, alphabet)), 1'b0, none);
               stream_left--;
            end
         end
         // sometimes leave the stream open so the next setting lands mid-stream
         if ($urandom_range(0, 2) != 0)
            send_word(lzwe_pkg::ACT_FLUSH, 8'($urandom_range(0, 255)), 1'b0, none);
         wait_idle();
      end

      send_word(lzwe_pkg::ACT_FLUSH, 8'h00, 1'b0, none);
      wait_idle();

      $display("Sent %0d words over %0d register settings; %0d codes checked",
               words_sent, phase_bits.size() + 1, codes_seen);
      $display("Flush codes %0d, widest code %0d bits, mismatches %0d",
               flush_codes, max_width_seen, errors);
      if (errors == 0 && pending_codes.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
